// ===== rtl/core/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure compensation block.
// No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps
package bpc_pkg;

   // Configuration register indexes (byte address = 4 * index)
   typedef enum logic [2:0] {
      REG_AC1_AC2   = 3'd0,
      REG_AC3_AC4   = 3'd1,
      REG_AC5_AC6   = 3'd2,
      REG_B1_B2     = 3'd3,
      REG_MC_MD     = 3'd4,
      REG_OVERSAMPL = 3'd5
   } bpc_reg_type;

   localparam int unsigned CSR_ADDR_W = 5;

   // Reset calibration values
   localparam logic [31:0] RST_AC1_AC2 = 32'd26804152;
   localparam logic [31:0] RST_AC3_AC4 = 32'd3352395749;
   localparam logic [31:0] RST_AC5_AC6 = 32'd2146785905;
   localparam logic [31:0] RST_B1_B2   = 32'd405667844;
   localparam logic [31:0] RST_MC_MD   = 32'd3724086068;
   localparam logic [1:0]  RST_OSS     = 2'd1;

   // Formula constants
   localparam logic signed [31:0] K_B6_OFFSET = 32'sd4000;
   localparam logic signed [31:0] K_P_SQ      = 32'sd3038;
   localparam logic signed [31:0] K_P_LIN     = -32'sd7357;
   localparam logic signed [31:0] K_P_OFFSET  = 32'sd3791;
   localparam logic signed [31:0] K_X3_BIAS   = 32'sd32768;

   // Divider widths
   localparam int unsigned D1_NUM_W = 27;
   localparam int unsigned D1_DEN_W = 17;
   localparam int unsigned D2_NUM_W = 32;
   localparam int unsigned D2_DEN_W = 17;

   // Sideband carried through the temperature divider
   typedef struct packed {
      logic signed [16:0] x1;
      logic [23:0]        up;
      logic               qneg;
      logic               err;
   } bpc_side1_type;

   // Sideband carried through the pressure divider
   typedef struct packed {
      logic signed [15:0] temp;
      logic               dbl;
      logic               err;
   } bpc_side2_type;

   // 50000 >> oversampling
   function automatic logic [15:0] b7_scale(input logic [1:0] oss);
      logic [15:0] k;
      case (oss)
         2'd0:    k = 16'd50000;
         2'd1:    k = 16'd25000;
         2'd2:    k = 16'd12500;
         default: k = 16'd6250;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/core/bpc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Standalone; carries an opaque sideband word alongside each request.
`timescale 1ns / 1ps
module bpc_div #(
   parameter int unsigned NUM_W  = 32,
   parameter int unsigned DEN_W  = 17,
   parameter int unsigned SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);

   // nq holds remaining numerator bits on top, quotient bits shift in below
   logic              v_ff   [NUM_W];
   logic [DEN_W-1:0]  rem_ff [NUM_W];
   logic [NUM_W-1:0]  nq_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff [NUM_W];
   logic [SIDE_W-1:0] side_ff[NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic              v_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [NUM_W-1:0]  nq_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  nq_in;

      if (i == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign nq_prev   = in_num;
         assign den_prev  = in_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign nq_prev   = nq_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      // one trial subtract
      always_comb begin
         trial  = {rem_prev, nq_prev[NUM_W-1]};
         ge     = (trial >= {1'b0, den_prev});
         rem_in = ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
         nq_in  = {nq_prev[NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv) begin
            v_ff[i] <= v_prev;
         end
         if (adv) begin
            rem_ff[i]  <= rem_in;
            nq_ff[i]   <= nq_in;
            den_ff[i]  <= den_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign out_quot  = nq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ===== rtl/core/barometric_pressure_compensation_top.sv =====
// Top level of the barometric pressure compensation pipeline.
// Depends on bpc_pkg and bpc_div.
`timescale 1ns / 1ps
// Converts a raw temperature word and raw pressure bytes into temperature in
// tenths of a degree and pressure in pascals using the stored calibration
// coefficients. Fully pipelined: one request is accepted per cycle unless the
// pipeline is stalled; each passes two bit-serial divider pipelines of 27
// and 32 stages plus 11 arithmetic and output stages. The whole pipeline
// stalls only while a finished result waits and rsp_ready is low. A zero
// divisor gives zero outputs with rsp_divide_error set. Calibration is written
// over the APB-style port at byte address 4*index; the user must write it only
// while no request is in flight, as the block does not enforce this.
module barometric_pressure_compensation_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [15:0]                       req_raw_temperature,
   input  logic [23:0]                       req_raw_pressure_bytes,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [15:0]                rsp_temperature_tenths,
   output logic signed [31:0]                rsp_pressure_pa,
   output logic                              rsp_divide_error,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bpc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import bpc_pkg::*;

   // ---------------- configuration registers ----------------
   logic [31:0] ac12_ff, ac34_ff, ac56_ff, b12_ff, mcmd_ff;
   logic [1:0]  oss_ff;
   logic        csr_wr;
   bpc_reg_type csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = bpc_reg_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ac12_ff <= RST_AC1_AC2;
         ac34_ff <= RST_AC3_AC4;
         ac56_ff <= RST_AC5_AC6;
         b12_ff  <= RST_B1_B2;
         mcmd_ff <= RST_MC_MD;
         oss_ff  <= RST_OSS;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_AC1_AC2:   ac12_ff <= pwdata;
            REG_AC3_AC4:   ac34_ff <= pwdata;
            REG_AC5_AC6:   ac56_ff <= pwdata;
            REG_B1_B2:     b12_ff  <= pwdata;
            REG_MC_MD:     mcmd_ff <= pwdata;
            REG_OVERSAMPL: oss_ff  <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   // register read-back
   always_comb begin
      unique case (csr_idx)
         REG_AC1_AC2:   prdata = ac12_ff;
         REG_AC3_AC4:   prdata = ac34_ff;
         REG_AC5_AC6:   prdata = ac56_ff;
         REG_B1_B2:     prdata = b12_ff;
         REG_MC_MD:     prdata = mcmd_ff;
         REG_OVERSAMPL: prdata = {30'd0, oss_ff};
         default:       prdata = '0;
      endcase
   end

   // coefficient fields
   logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [15:0]        ac4, ac5, ac6;
   assign ac1 = $signed(ac12_ff[31:16]);
   assign ac2 = $signed(ac12_ff[15:0]);
   assign ac3 = $signed(ac34_ff[31:16]);
   assign ac4 = ac34_ff[15:0];
   assign ac5 = ac56_ff[31:16];
   assign ac6 = ac56_ff[15:0];
   assign b1  = $signed(b12_ff[31:16]);
   assign b2  = $signed(b12_ff[15:0]);
   assign mc  = $signed(mcmd_ff[31:16]);
   assign md  = $signed(mcmd_ff[15:0]);

   // ---------------- pipeline flow ----------------
   logic adv;
   logic rsp_valid_ff;
   assign adv       = ~rsp_valid_ff | rsp_ready;
   assign req_ready = adv;

   // S1: X1 = ((UT - AC6) * AC5) >> 15, divisor X1 + MD
   logic               v1_ff;
   logic signed [16:0] x1t_in, x1t_ff;
   logic signed [17:0] den_in, den_ff;
   logic [23:0]        up_in, up1_ff;
   logic signed [16:0] dt;
   logic signed [33:0] p1;

   always_comb begin
      dt     = $signed({1'b0, req_raw_temperature}) - $signed({1'b0, ac6});
      p1     = dt * $signed({1'b0, ac5});
      x1t_in = $signed(p1[31:15]);
      den_in = 18'(x1t_in) + 18'(md);
      up_in  = req_raw_pressure_bytes >> (4'd8 - {2'b00, oss_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_valid;
      if (adv) begin
         x1t_ff <= x1t_in;
         den_ff <= den_in;
         up1_ff <= up_in;
      end
   end

   // S2: sign/magnitude split for the temperature divide
   logic                v2_ff;
   logic [D1_NUM_W-1:0] nmag_in, nmag_ff;
   logic [D1_DEN_W-1:0] dmag_in, dmag_ff;
   bpc_side1_type       s1_in, s1_ff;
   logic signed [17:0]  dneg;
   logic signed [16:0]  mcneg;

   always_comb begin
      dneg     = -den_ff;
      mcneg    = -17'(mc);
      dmag_in  = den_ff[17] ? dneg[D1_DEN_W-1:0] : den_ff[D1_DEN_W-1:0];
      nmag_in  = mc[15] ? {mcneg[15:0], 11'd0} : {1'b0, mc[14:0], 11'd0};
      s1_in.x1   = x1t_ff;
      s1_in.up   = up1_ff;
      s1_in.qneg = mc[15] ^ den_ff[17];
      s1_in.err  = (den_ff == 18'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         nmag_ff <= nmag_in;
         dmag_ff <= dmag_in;
         s1_ff   <= s1_in;
      end
   end

   // temperature divider: MC * 2048 / (X1 + MD)
   logic                d1_valid;
   logic [D1_NUM_W-1:0] d1_quot;
   logic [$bits(bpc_side1_type)-1:0] d1_side_bits;
   bpc_side1_type       d1_side;

   bpc_div #(
      .NUM_W  (D1_NUM_W),
      .DEN_W  (D1_DEN_W),
      .SIDE_W ($bits(bpc_side1_type))
   ) u_div_t (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v2_ff),
      .in_num    (nmag_ff),
      .in_den    (dmag_ff),
      .in_side   (s1_ff),
      .out_valid (d1_valid),
      .out_quot  (d1_quot),
      .out_side  (d1_side_bits)
   );
   assign d1_side = bpc_side1_type'(d1_side_bits);

   // S3: B5 = X1 + X2
   logic               v3_ff;
   logic signed [31:0] x2q, b5_in, b5_ff;
   logic [23:0]        up3_ff;
   logic               err3_ff;

   always_comb begin
      x2q   = $signed({5'd0, d1_quot});
      if (d1_side.qneg) x2q = -x2q;
      b5_in = 32'(d1_side.x1) + x2q;
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= d1_valid;
      if (adv) begin
         b5_ff   <= b5_in;
         up3_ff  <= d1_side.up;
         err3_ff <= d1_side.err;
      end
   end

   // S4: temperature, B6, B6 squared
   logic               v4_ff;
   logic signed [32:0] t33, tsh;
   logic signed [15:0] temp_in, temp4_ff;
   logic signed [31:0] b6_in, b6_ff, sqr_in, sqr_ff;
   logic [23:0]        up4_ff;
   logic               err4_ff;

   always_comb begin
      t33 = 33'(b5_ff) + 33'sd8;
      tsh = t33 >>> 4;
      if (tsh > 33'sd32767)       temp_in = 16'sd32767;
      else if (tsh < -33'sd32768) temp_in = -16'sd32768;
      else                        temp_in = tsh[15:0];
      b6_in  = b5_ff - K_B6_OFFSET;
      sqr_in = b6_in * b6_in;
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
      if (adv) begin
         temp4_ff <= temp_in;
         b6_ff    <= b6_in;
         sqr_ff   <= sqr_in;
         up4_ff   <= up3_ff;
         err4_ff  <= err3_ff;
      end
   end

   // S5: coefficient products
   logic               v5_ff;
   logic signed [31:0] sq;
   logic signed [31:0] pb2_ff, pac2_ff, pac3_ff, pb1_ff;
   logic signed [15:0] temp5_ff;
   logic [23:0]        up5_ff;
   logic               err5_ff;

   assign sq = sqr_ff >>> 12;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) begin
         pb2_ff   <= 32'(b2) * sq;
         pac2_ff  <= 32'(ac2) * b6_ff;
         pac3_ff  <= 32'(ac3) * b6_ff;
         pb1_ff   <= 32'(b1) * sq;
         temp5_ff <= temp4_ff;
         up5_ff   <= up4_ff;
         err5_ff  <= err4_ff;
      end
   end

   // S6: B3 and the X3 term for B4
   logic               v6_ff;
   logic signed [31:0] x3a, s0, s1, b3_in, b3_ff, x3b, xc_in, xc_ff;
   logic signed [15:0] temp6_ff;
   logic [23:0]        up6_ff;
   logic               err6_ff;

   always_comb begin
      x3a   = (pb2_ff >>> 11) + (pac2_ff >>> 11);
      s0    = (32'(ac1) <<< 2) + x3a;
      s1    = (s0 << oss_ff) + 32'sd2;
      // divide by 4 toward zero
      b3_in = s1[31] ? ((s1 + 32'sd3) >>> 2) : (s1 >>> 2);
      x3b   = ((pac3_ff >>> 13) + (pb1_ff >>> 16) + 32'sd2) >>> 2;
      xc_in = x3b + K_X3_BIAS;
   end

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
      if (adv) begin
         b3_ff    <= b3_in;
         xc_ff    <= xc_in;
         temp6_ff <= temp5_ff;
         up6_ff   <= up5_ff;
         err6_ff  <= err5_ff;
      end
   end

   // S7: B4 and UP - B3
   logic                v7_ff;
   logic [31:0]         p4;
   logic [D2_DEN_W-1:0] b4_7_ff;
   logic [31:0]         dif_ff;
   logic signed [15:0]  temp7_ff;
   logic                err7_ff;

   assign p4 = {16'd0, ac4} * $unsigned(xc_ff);

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff;
      if (adv) begin
         b4_7_ff  <= p4[31:15];
         dif_ff   <= {8'd0, up6_ff} - $unsigned(b3_ff);
         temp7_ff <= temp6_ff;
         err7_ff  <= err6_ff;
      end
   end

   // S8: B7
   logic                v8_ff;
   logic [31:0]         b7_ff;
   logic [D2_DEN_W-1:0] b4_8_ff;
   logic signed [15:0]  temp8_ff;
   logic                err8_ff;

   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (adv) v8_ff <= v7_ff;
      if (adv) begin
         b7_ff    <= dif_ff * {16'd0, b7_scale(oss_ff)};
         b4_8_ff  <= b4_7_ff;
         temp8_ff <= temp7_ff;
         err8_ff  <= err7_ff | (b4_7_ff == '0);
      end
   end

   // pressure divider: B7*2/B4, or (B7/B4)*2 when B7 has its top bit set
   logic                d2_valid;
   logic [D2_NUM_W-1:0] d2_num, d2_quot;
   bpc_side2_type       s2;
   logic [$bits(bpc_side2_type)-1:0] d2_side_bits;
   bpc_side2_type       d2_side;

   always_comb begin
      d2_num  = b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
      s2.temp = temp8_ff;
      s2.dbl  = b7_ff[31];
      s2.err  = err8_ff;
   end

   bpc_div #(
      .NUM_W  (D2_NUM_W),
      .DEN_W  (D2_DEN_W),
      .SIDE_W ($bits(bpc_side2_type))
   ) u_div_p (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v8_ff),
      .in_num    (d2_num),
      .in_den    (b4_8_ff),
      .in_side   (s2),
      .out_valid (d2_valid),
      .out_quot  (d2_quot),
      .out_side  (d2_side_bits)
   );
   assign d2_side = bpc_side2_type'(d2_side_bits);

   // S9: p, (p>>8)^2, -7357*p
   logic               v9_ff;
   logic signed [31:0] p_in, pd, p9_ff, sqp_ff, m2_ff;
   logic signed [15:0] temp9_ff;
   logic               err9_ff;

   always_comb begin
      p_in = d2_side.dbl ? $signed({d2_quot[30:0], 1'b0}) : $signed(d2_quot);
      pd   = p_in >>> 8;
   end

   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else if (adv) v9_ff <= d2_valid;
      if (adv) begin
         p9_ff    <= p_in;
         sqp_ff   <= pd * pd;
         m2_ff    <= K_P_LIN * p_in;
         temp9_ff <= d2_side.temp;
         err9_ff  <= d2_side.err;
      end
   end

   // S10: X1 * 3038
   logic               v10_ff;
   logic signed [31:0] t1_ff, p10_ff, m2_10_ff;
   logic signed [15:0] temp10_ff;
   logic               err10_ff;

   always_ff @(posedge clock) begin
      if (reset) v10_ff <= 1'b0;
      else if (adv) v10_ff <= v9_ff;
      if (adv) begin
         t1_ff     <= sqp_ff * K_P_SQ;
         p10_ff    <= p9_ff;
         m2_10_ff  <= m2_ff;
         temp10_ff <= temp9_ff;
         err10_ff  <= err9_ff;
      end
   end

   // S11: final correction and output register
   logic signed [31:0] pf_in, pres_ff;
   logic signed [15:0] tout_ff;
   logic               derr_ff;

   assign pf_in = p10_ff + (((t1_ff >>> 16) + (m2_10_ff >>> 16) + K_P_OFFSET) >>> 4);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= v10_ff;
      if (adv) begin
         pres_ff <= err10_ff ? 32'sd0 : pf_in;
         tout_ff <= err10_ff ? 16'sd0 : temp10_ff;
         derr_ff <= err10_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_temperature_tenths = tout_ff;
   assign rsp_pressure_pa        = pres_ff;
   assign rsp_divide_error       = derr_ff;

`ifndef NO_ASSERTIONS
   // an error result carries zero values
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && derr_ff) |-> (pres_ff == 32'sd0 && tout_ff == 16'sd0))
      else $error("divide error with nonzero result");

   // a stall freezes the first stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v1_ff))
      else $error("pipeline moved during stall");

   // a request accepted while unstalled reaches stage one
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted request lost at entry");
`endif

endmodule

// ===== sim/tb_barometric_pressure_compensation_top.sv =====
// Self-checking testbench for barometric_pressure_compensation_top: random and
// directed requests, calibration writes over APB, scoreboard predicts each result.
// Depends on bpc_pkg and the RTL of the compensation block.
`timescale 1ns / 1ps

// Expected-result store and pressure compensation predictor
class pressure_scoreboard;
   typedef struct {
      logic signed [15:0] temp;
      logic signed [31:0] press;
      logic               err;
   } comp_result_type;

   logic [31:0] cal[6];
   comp_result_type pending[$];
   int mismatches;

   function new();
      cal[0] = bpc_pkg::RST_AC1_AC2;
      cal[1] = bpc_pkg::RST_AC3_AC4;
      cal[2] = bpc_pkg::RST_AC5_AC6;
      cal[3] = bpc_pkg::RST_B1_B2;
      cal[4] = bpc_pkg::RST_MC_MD;
      cal[5] = {30'd0, bpc_pkg::RST_OSS};
      mismatches = 0;
   endfunction

   // Compensation formula, 32-bit wrap, floor right shifts
   function comp_result_type compensate(logic [15:0] ut_raw, logic [23:0] up_raw);
      comp_result_type r;
      logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
      logic [31:0] ac4, up, b4, b7, pu, s;
      logic signed [31:0] x1, x2, x3, den, b5, b6, sq, b3, p, pp;
      logic signed [63:0] t;
      logic [1:0] oss;
      ac1 = $signed(cal[0][31:16]); ac2 = $signed(cal[0][15:0]);
      ac3 = $signed(cal[1][31:16]); ac4 = {16'd0, cal[1][15:0]};
      ac5 = {16'd0, cal[2][31:16]}; ac6 = {16'd0, cal[2][15:0]};
      b1 = $signed(cal[3][31:16]); b2 = $signed(cal[3][15:0]);
      mc = $signed(cal[4][31:16]); md = $signed(cal[4][15:0]);
      oss = cal[5][1:0];
      up = {8'd0, up_raw} >> (8 - oss);
      r.temp = 0; r.press = 0; r.err = 1;
      x1 = ($signed({16'd0, ut_raw}) - ac6) * ac5;
      x1 = x1 >>> 15;
      den = x1 + md;
      if (den == 0) return r;
      x2 = 32'($signed(64'(mc) * 2048) / 64'(den));
      b5 = x1 + x2;
      t = (64'(b5) + 8) >>> 4;
      r.temp = t > 32767 ? 16'sd32767 : (t < -32768 ? -16'sd32768 : t[15:0]);
      b6 = b5 - 4000;
      sq = (b6 * b6) >>> 12;
      x1 = (b2 * sq) >>> 11;
      x2 = (ac2 * b6) >>> 11;
      x3 = x1 + x2;
      s = ((ac1 * 4 + x3) << oss) + 2;
      b3 = $signed(s) / 4;
      x1 = (ac3 * b6) >>> 13;
      x2 = (b1 * sq) >>> 16;
      x3 = (x1 + x2 + 2) >>> 2;
      b4 = (ac4 * 32'(x3 + 32768)) >> 15;
      if (b4 == 0) begin
         r.temp = 0;
         return r;
      end
      b7 = (up - b3) * (32'd50000 >> oss);
      if (b7 < 32'h8000_0000) pu = (b7 * 2) / b4;
      else pu = (b7 / b4) * 2;
      p = pu;
      pp = p >>> 8;
      x1 = pp * pp;
      x1 = (x1 * 3038) >>> 16;
      x2 = (-32'sd7357 * p) >>> 16;
      r.press = p + ((x1 + x2 + 3791) >>> 4);
      r.err = 0;
      return r;
   endfunction

   function void note_request(logic [15:0] ut, logic [23:0] up);
      pending.push_back(compensate(ut, up));
   endfunction

   function void check_result(logic signed [15:0] temp, logic signed [31:0] press,
                              logic err);
      comp_result_type e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: unexpected result");
         return;
      end
      e = pending.pop_front();
      if (e.temp !== temp || e.press !== press || e.err !== err) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: exp t=%0d p=%0d e=%0b got t=%0d p=%0d e=%0b",
                     e.temp, e.press, e.err, temp, press, err);
      end
   endfunction
endclass

module tb_barometric_pressure_compensation_top;
   import bpc_pkg::*;

   localparam int LATENCY    = 70;
   localparam int WATCHDOG   = 20000;
   localparam int NUM_RANDOM = 1830;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready;
   logic [15:0] req_raw_temperature = 0;
   logic [23:0] req_raw_pressure_bytes = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [15:0] rsp_temperature_tenths;
   logic signed [31:0] rsp_pressure_pa;
   logic rsp_divide_error;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_W-1:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   logic pready;

   pressure_scoreboard board = new();
   int idle_cycles = 0;
   bit rsp_steady = 0;

   barometric_pressure_compensation_top DUT (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Result checking and receiver stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_temperature_tenths, rsp_pressure_pa, rsp_divide_error);
         rsp_ready <= rsp_steady || ($urandom_range(99) >= 20);
      end
   end

   // Watchdog on cycles with no accepted request, result or register access
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("barometric_pressure_compensation_top regression: fail");
         $finish;
      end
   end

   task automatic csr_write(bpc_reg_type idx, logic [31:0] value);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= CSR_ADDR_W'(4 * idx); pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      board.cal[idx] = (idx == REG_OVERSAMPL) ? (value & 32'd3) : value;
   endtask

   task automatic send_request(logic [15:0] ut, logic [23:0] up, bit gaps);
      while (gaps && $urandom_range(99) < 20) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_raw_temperature <= ut;
      req_raw_pressure_bytes <= up;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(ut, up);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // Random calibration near the stock values, sometimes fully random
   task automatic random_cal(bit wild);
      csr_write(REG_AC1_AC2, wild ? $urandom : {16'(6000 + $urandom_range(4000)),
                                               16'(-1500 + $urandom_range(1000))});
      csr_write(REG_AC3_AC4, wild ? $urandom : {16'(-15000 + $urandom_range(2000)),
                                               16'(30000 + $urandom_range(8000))});
      csr_write(REG_AC5_AC6, wild ? $urandom : {16'(24000 + $urandom_range(2000)),
                                               16'(20000 + $urandom_range(3000))});
      csr_write(REG_B1_B2, wild ? $urandom : {16'(5000 + $urandom_range(2000)),
                                             16'(20 + $urandom_range(40))});
      csr_write(REG_MC_MD, wild ? $urandom : {16'(-12000 + $urandom_range(2000)),
                                             16'(2000 + $urandom_range(2000))});
   endtask

   initial begin
      bit gaps;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes under each oversampling setting
      for (int o = 0; o < 4; o++) begin
         csr_write(REG_OVERSAMPL, o);
         send_request(16'h0000, 24'h000000, 0);
         send_request(16'hFFFF, 24'hFFFFFF, 0);
         send_request(16'd27898, 24'h5D2300, 0);
         send_request(16'h5555, 24'hAAAAAA, 0);
         req_valid <= 0;
         drain();
      end
      // Zero temperature divisor: ac5 = 0 so x1 = 0, md = 0
      csr_write(REG_MC_MD, 32'hD4BD_0000);
      csr_write(REG_AC5_AC6, 32'h0000_5000);
      send_request(16'd1234, 24'h123456, 0);
      req_valid <= 0;
      drain();
      // Zero b4: ac4 = 0
      csr_write(REG_MC_MD, RST_MC_MD);
      csr_write(REG_AC5_AC6, RST_AC5_AC6);
      csr_write(REG_AC3_AC4, 32'hC5E4_0000);
      send_request(16'd27898, 24'h5D2300, 0);
      req_valid <= 0;
      drain();
      // Extreme calibration words
      csr_write(REG_AC1_AC2, 32'h7FFF_8000);
      csr_write(REG_AC3_AC4, 32'h8000_FFFF);
      csr_write(REG_AC5_AC6, 32'hFFFF_FFFF);
      csr_write(REG_B1_B2, 32'h7FFF_8000);
      csr_write(REG_MC_MD, 32'h8000_7FFF);
      send_request(16'h0000, 24'hFFFFFF, 0);
      send_request(16'hFFFF, 24'h000000, 0);
      req_valid <= 0;
      drain();

      // Random phases with fresh calibration
      for (int ph = 0; ph < 10; ph++) begin
         random_cal(ph % 4 == 3);
         csr_write(REG_OVERSAMPL, $urandom_range(3));
         rsp_steady = (ph == 4);
         gaps = (ph != 4);
         for (int i = 0; i < NUM_RANDOM / 10; i++)
            send_request(16'($urandom), 24'($urandom), gaps);
         req_valid <= 0;
         drain();
      end

      if (board.mismatches == 0)
         $display("barometric_pressure_compensation_top regression: pass");
      else
         $display("barometric_pressure_compensation_top regression: fail");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/bpc_pkg.sv
rtl/core/bpc_div.sv
rtl/core/barometric_pressure_compensation_top.sv
sim/tb_barometric_pressure_compensation_top.sv
